// ----- hdl/glyph_text_pixel_writer_macros.svh -----
// Assertion macros for the glyph text pixel writer checker.
`ifndef GLYPH_TEXT_PIXEL_WRITER_MACROS_SVH
`define GLYPH_TEXT_PIXEL_WRITER_MACROS_SVH

// Clocked check, skipped while reset is asserted.
`define GTPW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define GTPW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/gtpw_pkg.sv -----
// Shared types, constants and glyph ROM for the glyph text pixel writer.
`default_nettype none

package gtpw_pkg;

  localparam int COORD_W   = 14;
  localparam int ADDR_W    = 25;
  localparam int MASK_W    = 40;
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int PEN_MAX   = 8191;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_LINE_STRIDE,
    REG_DRAW_COLOR
  } gtpw_reg_t;

  // One character request after clipping: bit dx*8+dy of mask is a visible set pixel.
  typedef struct packed {
    logic signed [COORD_W-1:0] col;
    logic signed [COORD_W-1:0] row;
    logic [MASK_W-1:0]         mask;
  } gtpw_task_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              last;
  } gtpw_wr_t;

  // Column 0 in the low byte, bit dy of each byte is row dy.
  function automatic logic [MASK_W-1:0] glyph_bits(input logic [7:0] code);
    logic [MASK_W-1:0] g;
    g = '0;
    if (!code[7]) begin
      case (code[6:0])
        7'd33:   g = {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
        7'd44:   g = {8'h00, 8'h00, 8'h06, 8'h05, 8'h00};
        7'd72:   g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
        7'd87:   g = {8'h7C, 8'h02, 8'h01, 8'h02, 8'h7C};
        7'd97:   g = {8'h78, 8'h54, 8'h54, 8'h54, 8'h20};
        7'd100:  g = {8'h7F, 8'h14, 8'h14, 8'h14, 8'h08};
        7'd101:  g = {8'h18, 8'h54, 8'h54, 8'h54, 8'h38};
        7'd108:  g = {8'h00, 8'h40, 8'h7F, 8'h41, 8'h00};
        7'd111:  g = {8'h38, 8'h44, 8'h44, 8'h44, 8'h38};
        7'd114:  g = {8'h08, 8'h04, 8'h04, 8'h08, 8'h7C};
        default: g = '0;
      endcase
    end
    return g;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/glyph_text_pixel_writer.sv -----
// Top level of the glyph text pixel writer: register file, queues, front and back ends.
`default_nettype none

// Turns character codes into framebuffer writes from a 5x7 font. The front end
// takes one character per cycle while the request queue has room and drops
// characters with no visible pixel (high codes, blank glyphs, fully clipped).
// The back end emits one write per cycle for each visible set pixel while the
// result queue has room, and loads a character only once the last write of
// the one before has issued. Each write passes the a and b registers, with the
// single address multiplier between them, before the result queue.
// pixel_color follows draw_color_r directly. No clearing pass after reset.
module glyph_text_pixel_writer #(
  parameter int FRAME_MAX  = 4096,
  parameter int CHAR_PITCH = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_starts_text,
  input  wire logic signed [13:0] in_text_x,
  input  wire logic signed [13:0] in_text_y,
  output logic             empty,
  input  wire logic        pop,
  output logic [24:0]      out_pixel_address,
  output logic [31:0]      out_pixel_color,
  output logic             out_last_pixel,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import gtpw_pkg::*;

  localparam int TASK_DEPTH = 2;
  localparam int OUT_DEPTH  = 4;

  logic [12:0] frame_width_r, frame_height_r;
  logic [13:0] line_stride_r;
  logic [31:0] draw_color_r;
  logic        cfg_wr;
  gtpw_reg_t   cfg_sel;

  gtpw_task_t  front_task, back_task;
  logic        front_push, task_empty, task_pop;
  gtpw_wr_t    back_wr, out_wr;
  logic        back_push, out_full;
  logic [$clog2(OUT_DEPTH):0] out_level;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = gtpw_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 13'd640;
      frame_height_r <= 13'd480;
      line_stride_r  <= 14'd640;
      draw_color_r   <= 32'hFFFF_FFFF;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[12:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[12:0];
        REG_LINE_STRIDE:  line_stride_r  <= pwdata[13:0];
        REG_DRAW_COLOR:   draw_color_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_FRAME_WIDTH:  prdata = {19'd0, frame_width_r};
      REG_FRAME_HEIGHT: prdata = {19'd0, frame_height_r};
      REG_LINE_STRIDE:  prdata = {18'd0, line_stride_r};
      REG_DRAW_COLOR:   prdata = draw_color_r;
      default:          prdata = '0;
    endcase
  end

  gtpw_front #(
    .FRAME_MAX  (FRAME_MAX),
    .CHAR_PITCH (CHAR_PITCH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (push && !full),
    .char_code    (in_char_code),
    .starts_text  (in_starts_text),
    .text_x       (in_text_x),
    .text_y       (in_text_y),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .task_push    (front_push),
    .task_out     (front_task)
  );

  gtpw_fifo #(
    .WIDTH ($bits(gtpw_task_t)),
    .DEPTH (TASK_DEPTH)
  ) u_task_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_push),
    .din   (front_task),
    .full  (full),
    .pop   (task_pop),
    .dout  (back_task),
    .empty (task_empty),
    .level ()
  );

  gtpw_back #(
    .FRAME_MAX (FRAME_MAX),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .task_in     (back_task),
    .task_empty  (task_empty),
    .task_pop    (task_pop),
    .line_stride (line_stride_r),
    .out_level   (out_level),
    .wr_push     (back_push),
    .wr_out      (back_wr)
  );

  gtpw_fifo #(
    .WIDTH ($bits(gtpw_wr_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (back_push),
    .din   (back_wr),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_wr),
    .empty (empty),
    .level (out_level)
  );

  assign out_pixel_address = out_wr.addr;
  assign out_last_pixel    = out_wr.last && !out_full || out_wr.last;
  assign out_pixel_color   = draw_color_r;

endmodule

`default_nettype wire

// ----- hdl/gtpw_fifo.sv -----
// Small first-in first-out queue with show-ahead output and fill level.
`default_nettype none

module gtpw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire logic [WIDTH-1:0]         din,
  output logic                          full,
  input  wire logic                     pop,
  output logic [WIDTH-1:0]              dout,
  output logic                          empty,
  output logic [$clog2(DEPTH):0]        level
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign level   = cnt_r;
  assign dout    = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gtpw_front.sv -----
// Front end: pen tracking, glyph lookup and per-pixel clipping into a request.
`default_nettype none

module gtpw_front #(
  parameter int FRAME_MAX  = 4096,
  parameter int CHAR_PITCH = 6
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            accept,
  input  wire logic [7:0]                      char_code,
  input  wire logic                            starts_text,
  input  wire logic signed [gtpw_pkg::COORD_W-1:0] text_x,
  input  wire logic signed [gtpw_pkg::COORD_W-1:0] text_y,
  input  wire logic [12:0]                     frame_width,
  input  wire logic [12:0]                     frame_height,
  output logic                                 task_push,
  output gtpw_pkg::gtpw_task_t                 task_out
);

  import gtpw_pkg::*;

  logic signed [COORD_W-1:0] pen_col_r, pen_col_nxt;
  logic signed [COORD_W-1:0] pen_row_r, pen_row_nxt;
  logic signed [COORD_W-1:0] cur_col, cur_row;
  logic [COORD_W-1:0]        wlim, hlim;
  logic [COORD_W:0]          col_sum [GLYPH_COLS];
  logic [COORD_W:0]          row_sum [GLYPH_ROWS];
  logic [GLYPH_COLS-1:0]     col_vis;
  logic [GLYPH_ROWS-1:0]     row_vis;
  logic [MASK_W-1:0]         glyph, mask;

  always_comb begin
    cur_col = starts_text ? text_x : pen_col_r;
    cur_row = starts_text ? text_y : pen_row_r;
    wlim = ({1'b0, frame_width} > COORD_W'(FRAME_MAX)) ? COORD_W'(FRAME_MAX)
                                                         : {1'b0, frame_width};
    hlim = ({1'b0, frame_height} > COORD_W'(FRAME_MAX)) ? COORD_W'(FRAME_MAX)
                                                          : {1'b0, frame_height};
    for (int dx = 0; dx < GLYPH_COLS; dx++) begin
      col_sum[dx] = {cur_col[COORD_W-1], cur_col} + (COORD_W+1)'(dx);
      col_vis[dx] = !col_sum[dx][COORD_W] && (col_sum[dx][COORD_W-1:0] < wlim);
    end
    for (int dy = 0; dy < GLYPH_ROWS; dy++) begin
      row_sum[dy] = {cur_row[COORD_W-1], cur_row} + (COORD_W+1)'(dy);
      row_vis[dy] = !row_sum[dy][COORD_W] && (row_sum[dy][COORD_W-1:0] < hlim);
    end
    glyph = glyph_bits(char_code);
    mask  = '0;
    for (int dx = 0; dx < GLYPH_COLS; dx++) begin
      for (int dy = 0; dy < GLYPH_ROWS; dy++) begin
        mask[dx*8+dy] = glyph[dx*8+dy] && col_vis[dx] && row_vis[dy];
      end
    end

    pen_col_nxt = pen_col_r;
    pen_row_nxt = pen_row_r;
    if (accept) begin
      pen_row_nxt = cur_row;
      if (cur_col > $signed(COORD_W'(PEN_MAX - CHAR_PITCH))) begin
        pen_col_nxt = COORD_W'(PEN_MAX);
      end else begin
        pen_col_nxt = cur_col + $signed(COORD_W'(CHAR_PITCH));
      end
    end

    task_push     = accept && (mask != '0);
    task_out.col  = cur_col;
    task_out.row  = cur_row;
    task_out.mask = mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_col_r <= '0;
      pen_row_r <= '0;
    end else begin
      pen_col_r <= pen_col_nxt;
      pen_row_r <= pen_row_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gtpw_back.sv -----
// Back end: walks the visible pixel mask, one frame address per cycle unless stalled.
`default_nettype none

module gtpw_back #(
  parameter int FRAME_MAX = 4096,
  parameter int OUT_DEPTH = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire gtpw_pkg::gtpw_task_t            task_in,
  input  wire logic                            task_empty,
  output logic                                 task_pop,
  input  wire logic [13:0]                     line_stride,
  input  wire logic [$clog2(OUT_DEPTH):0]      out_level,
  output logic                                 wr_push,
  output gtpw_pkg::gtpw_wr_t                   wr_out
);

  import gtpw_pkg::*;

  localparam int PXW = $clog2(FRAME_MAX);
  localparam int LVW = $clog2(OUT_DEPTH) + 2;
  localparam int PW  = (PXW + 15 > ADDR_W) ? PXW + 15 : ADDR_W;

  logic [MASK_W-1:0]         mask_r, mask_nxt, mask_rest;
  logic signed [COORD_W-1:0] col_r, row_r;
  logic [5:0]                idx;
  logic [COORD_W:0]          px_sum, py_sum;
  logic                      space, issue;
  logic                      a_vld_r, a_last_r;
  logic [PXW-1:0]            a_px_r, a_py_r;
  logic                      b_vld_r, b_last_r;
  logic [ADDR_W-1:0]         b_addr_r;
  logic [PW-1:0]             addr_full;

  always_comb begin
    idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        idx = 6'(i);
      end
    end
    mask_rest = mask_r & (mask_r - MASK_W'(1));
    space = (LVW'(out_level) + LVW'(a_vld_r) + LVW'(b_vld_r)) < LVW'(OUT_DEPTH);
    issue = (mask_r != '0) && space;
    task_pop = (mask_r == '0) && !task_empty;
    if (task_pop) begin
      mask_nxt = task_in.mask;
    end else if (issue) begin
      mask_nxt = mask_rest;
    end else begin
      mask_nxt = mask_r;
    end
    px_sum = {col_r[COORD_W-1], col_r} + (COORD_W+1)'(idx[5:3]);
    py_sum = {row_r[COORD_W-1], row_r} + (COORD_W+1)'(idx[2:0]);
    addr_full = PW'(a_py_r) * PW'(line_stride) + PW'(a_px_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      mask_r  <= mask_nxt;
      a_vld_r <= issue;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (task_pop) begin
      col_r <= task_in.col;
      row_r <= task_in.row;
    end
    a_px_r   <= px_sum[PXW-1:0];
    a_py_r   <= py_sum[PXW-1:0];
    a_last_r <= (mask_rest == '0);
    b_addr_r <= addr_full[ADDR_W-1:0];
    b_last_r <= a_last_r;
  end

  assign wr_push     = b_vld_r;
  assign wr_out.addr = b_addr_r;
  assign wr_out.last = b_last_r;

endmodule

`default_nettype wire

// ----- hdl/gtpw_checker.sv -----
// Port-level checks for the glyph text pixel writer, bound to the top level.
`default_nettype none

`include "glyph_text_pixel_writer_macros.svh"

module gtpw_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        push,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [24:0] out_pixel_address,
  input wire logic        out_last_pixel,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [3:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  import gtpw_pkg::*;

  `GTPW_ASSERT_ALWAYS(a_pready_high, clk, pready, "pready dropped")

  `GTPW_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (empty && !full), "queues not cleared by reset")

  `GTPW_ASSERT(a_result_holds, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(out_pixel_address) && $stable(out_last_pixel)), "waiting result changed")

  `GTPW_ASSERT(a_color_readback, clk, rst_n, (psel && penable && pwrite && paddr[3:2] == REG_DRAW_COLOR) ##1 (paddr[3:2] == REG_DRAW_COLOR) |-> (prdata == $past(pwdata)), "draw color readback mismatch")

endmodule

bind glyph_text_pixel_writer gtpw_checker u_gtpw_checker (.*);

`default_nettype wire

// ----- tb/sv/glyph_text_pixel_writer_test.sv -----
// Self-checking testbench for the glyph text pixel writer: predicted writes vs. DUT output.
`timescale 1ns / 100ps

module glyph_text_pixel_writer_test;
  import gtpw_pkg::*;

  localparam int PEN_STEP      = 6;
  localparam int FRAME_LIMIT   = 4096;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 500000;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [31:0]       color;
    logic              last;
  } pixel_write_t;

  class pixel_write_tracker;
    logic [12:0]  frame_width;
    logic [12:0]  frame_height;
    logic [13:0]  line_stride;
    logic [31:0]  draw_color;
    int           pen_col;
    int           pen_row;
    pixel_write_t due_writes[$];
    int           errors;

    function new();
      frame_width  = 13'd640;
      frame_height = 13'd480;
      line_stride  = 14'd640;
      draw_color   = 32'hFFFF_FFFF;
      pen_col      = 0;
      pen_row      = 0;
      errors       = 0;
    endfunction

    function void set_reg(gtpw_reg_t r, logic [31:0] v);
      case (r)
        REG_FRAME_WIDTH:  frame_width  = v[12:0];
        REG_FRAME_HEIGHT: frame_height = v[12:0];
        REG_LINE_STRIDE:  line_stride  = v[13:0];
        REG_DRAW_COLOR:   draw_color   = v;
        default: ;
      endcase
    endfunction

    function logic [7:0] font_column(logic [7:0] code, int dx);
      logic [7:0] c [GLYPH_COLS];
      c = '{default: 8'h00};
      case (code)
        8'd33:  c = '{8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
        8'd44:  c = '{8'h00, 8'h05, 8'h06, 8'h00, 8'h00};
        8'd72:  c = '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
        8'd87:  c = '{8'h7C, 8'h02, 8'h01, 8'h02, 8'h7C};
        8'd97:  c = '{8'h20, 8'h54, 8'h54, 8'h54, 8'h78};
        8'd100: c = '{8'h08, 8'h14, 8'h14, 8'h14, 8'h7F};
        8'd101: c = '{8'h38, 8'h54, 8'h54, 8'h54, 8'h18};
        8'd108: c = '{8'h00, 8'h41, 8'h7F, 8'h40, 8'h00};
        8'd111: c = '{8'h38, 8'h44, 8'h44, 8'h44, 8'h38};
        8'd114: c = '{8'h7C, 8'h08, 8'h04, 8'h04, 8'h08};
        default: ;
      endcase
      return c[dx];
    endfunction

    function void note_char(logic [7:0] code, logic starts, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y);
      int wlim;
      int hlim;
      int px;
      int py;
      logic [7:0] bits;
      logic [63:0] full_addr;
      logic [ADDR_W-1:0] hits[$];
      pixel_write_t w;
      wlim = (frame_width > FRAME_LIMIT) ? FRAME_LIMIT : int'(frame_width);
      hlim = (frame_height > FRAME_LIMIT) ? FRAME_LIMIT : int'(frame_height);
      if (starts) begin
        pen_col = x;
        pen_row = y;
      end
      if (!code[7]) begin
        for (int dx = 0; dx < GLYPH_COLS; dx++) begin
          bits = font_column(code, dx);
          for (int dy = 0; dy < GLYPH_ROWS; dy++) begin
            px = pen_col + dx;
            py = pen_row + dy;
            if (bits[dy] && px >= 0 && px < wlim && py >= 0 && py < hlim) begin
              full_addr = longint'(py) * longint'(line_stride) + longint'(px);
              hits.push_back(full_addr[ADDR_W-1:0]);
            end
          end
        end
      end
      foreach (hits[i]) begin
        w.addr  = hits[i];
        w.color = draw_color;
        w.last  = (i == hits.size() - 1);
        due_writes.push_back(w);
      end
      if (pen_col > PEN_MAX - PEN_STEP) pen_col = PEN_MAX;
      else pen_col += PEN_STEP;
    endfunction

    function void check_write(logic [ADDR_W-1:0] addr, logic [31:0] color, logic last);
      pixel_write_t w;
      if (due_writes.size() == 0) begin
        $error("pixel write with no pending request: address %0h", addr);
        errors++;
        return;
      end
      w = due_writes.pop_front();
      if (addr !== w.addr) begin
        $error("pixel_address: expected %0h, got %0h", w.addr, addr);
        errors++;
      end
      if (color !== w.color) begin
        $error("pixel_color: expected %0h, got %0h", w.color, color);
        errors++;
      end
      if (last !== w.last) begin
        $error("last_pixel: expected %0b, got %0b", w.last, last);
        errors++;
      end
    endfunction

    function int num_pending();
      return due_writes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [7:0] in_char_code = '0;
  logic in_starts_text = 1'b0;
  logic signed [COORD_W-1:0] in_text_x = '0;
  logic signed [COORD_W-1:0] in_text_y = '0;
  logic empty;
  logic pop = 1'b0;
  logic [ADDR_W-1:0] out_pixel_address;
  logic [31:0] out_pixel_color;
  logic out_last_pixel;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pixel_write_tracker sb = new();
  int cycles = 0;
  int rx_mode = 0;
  int rx_hold = 0;
  logic [7:0] drawn_codes [11] = '{8'd32, 8'd33, 8'd44, 8'd72, 8'd87, 8'd97, 8'd100,
                                   8'd101, 8'd108, 8'd111, 8'd114};

  glyph_text_pixel_writer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_char_code     (in_char_code),
    .in_starts_text   (in_starts_text),
    .in_text_x        (in_text_x),
    .in_text_y        (in_text_y),
    .empty            (empty),
    .pop              (pop),
    .out_pixel_address(out_pixel_address),
    .out_pixel_color  (out_pixel_color),
    .out_last_pixel   (out_last_pixel),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) sb.note_char(in_char_code, in_starts_text, in_text_x, in_text_y);
      if (pop && !empty) sb.check_write(out_pixel_address, out_pixel_color, out_last_pixel);
    end
  end

  always @(negedge clk) begin
    if (rx_hold == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_hold = $urandom_range(20, 150);
    end
    rx_hold--;
    case (rx_mode)
      0: begin
        pop <= 1'b1;
      end
      1: begin
        pop <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        pop <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  task automatic send_char(logic [7:0] code, logic starts, logic signed [COORD_W-1:0] x,
                           logic signed [COORD_W-1:0] y);
    @(negedge clk);
    push           <= 1'b1;
    in_char_code   <= code;
    in_starts_text <= starts;
    in_text_x      <= x;
    in_text_y      <= y;
    do @(posedge clk); while (full);
  endtask

  task automatic idle_sender(int n);
    @(negedge clk);
    push <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_idle();
    idle_sender(1);
    while (sb.num_pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(gtpw_reg_t r, logic [31:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(4 * int'(r));
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(r, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord(int span);
    int v;
    if ($urandom_range(0, 4) == 0) v = $urandom;
    else v = int'($urandom_range(0, span + 8)) - 6;
    return v[COORD_W-1:0];
  endfunction

  task automatic send_random(int n, int span_x, int span_y);
    int burst;
    int r;
    logic [7:0] code;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        if (i > 0) idle_sender($urandom_range(1, 40));
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
      end
      r = $urandom_range(0, 9);
      if (r < 6) code = drawn_codes[$urandom_range(0, 10)];
      else if (r < 8) code = 8'($urandom_range(0, 127));
      else code = 8'($urandom_range(128, 255));
      send_char(code, $urandom_range(0, 4) == 0, pick_coord(span_x), pick_coord(span_y));
      burst--;
    end
  endtask

  task automatic run_phase(logic [12:0] w, logic [12:0] h, logic [13:0] s, logic [31:0] color,
                           int n);
    wait_idle();
    reg_write(REG_FRAME_WIDTH, 32'(w));
    reg_write(REG_FRAME_HEIGHT, 32'(h));
    reg_write(REG_LINE_STRIDE, 32'(s));
    reg_write(REG_DRAW_COLOR, color);
    send_random(n, (w > FRAME_LIMIT) ? FRAME_LIMIT : int'(w),
                (h > FRAME_LIMIT) ? FRAME_LIMIT : int'(h));
  endtask

  initial begin
    string greeting;
    greeting = "Hello, World!";
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < greeting.len(); i++) begin
      send_char(greeting[i], i == 0, 14'sd2, 14'sd3);
    end
    idle_sender(3);
    send_char(8'd0, 1'b0, '0, '0);
    send_char(8'd127, 1'b0, '0, '0);
    send_char(8'd128, 1'b0, '0, '0);
    send_char(8'd255, 1'b0, '0, '0);
    send_char(8'd72, 1'b1, -14'sd3, -14'sd2);
    send_char(8'd87, 1'b1, 14'sd636, 14'sd476);
    send_char(8'd108, 1'b1, 14'sd8191, 14'sd8191);
    send_char(8'd111, 1'b0, '0, '0);
    send_char(8'd72, 1'b1, -14'sd8192, -14'sd8192);
    send_char(8'd100, 1'b1, 14'sd8188, 14'sd0);
    send_char(8'd101, 1'b0, '0, '0);

    run_phase(13'd8191, 13'd8191, 14'd16383, 32'h0000_0000, 50);
    run_phase(13'd1, 13'd1, 14'd1, $urandom, 20);
    run_phase(13'd0, 13'd0, 14'd0, 32'hFFFF_FFFF, 10);
    run_phase(13'd4096, 13'd4096, 14'd8192, $urandom, 50);
    run_phase(13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)),
              14'($urandom_range(1, 16383)), $urandom, 60);
    run_phase(13'd640, 13'd480, 14'd640, $urandom, 60);
    wait_idle();

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
